### rtl/lrast_pkg.sv
`default_nettype none

package lrast_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int COLOR_BITS_DEF = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic last;
    } sts_t;

endpackage

`default_nettype wire

### rtl/lrast_ctrl.sv
`default_nettype none

module lrast_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire              m_ready,
    input  lrast_pkg::sts_t  sts,
    output lrast_pkg::cmd_t  cmd
);
    import lrast_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                m_valid  = 1'b1;
                cmd.step = m_ready && !sts.last;
                if (m_ready && sts.last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/lrast_dp.sv
`default_nettype none

module lrast_dp #(
    parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF,
    parameter int COLOR_BITS = lrast_pkg::COLOR_BITS_DEF
) (
    input  wire                   aclk,
    input  lrast_pkg::cmd_t       cmd,
    output lrast_pkg::sts_t       sts,
    input  wire [COORD_BITS-1:0]  x_start,
    input  wire [COORD_BITS-1:0]  y_start,
    input  wire [COORD_BITS-1:0]  x_end,
    input  wire [COORD_BITS-1:0]  y_end,
    input  wire [COLOR_BITS-1:0]  color,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [COLOR_BITS-1:0] pixel_color,
    output logic                  last_pixel
);
    import lrast_pkg::*;

    localparam int DW = COORD_BITS + 3;

    logic [COORD_BITS-1:0] x_reg, y_reg, xe_reg, ye_reg, rem_reg;
    logic [COORD_BITS-1:0] x_next, y_next, rem_next;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  x_dec_reg, y_dec_reg, x_major_reg;
    logic                  x_dec_next, y_dec_next, x_major_next;
    logic signed [DW-1:0]  di_reg, inc_a_reg, inc_b_reg;
    logic signed [DW-1:0]  di_next, inc_a_next, inc_b_next;

    logic [COORD_BITS-1:0] adx, ady, major_len, minor_len;
    logic                  x_dec, y_dec, x_major;
    logic                  step_x, step_y;

    // setup: distances, directions, major axis and increment terms
    always_comb begin
        x_dec      = xe_reg < x_reg;
        y_dec      = ye_reg < y_reg;
        adx        = x_dec ? x_reg - xe_reg : xe_reg - x_reg;
        ady        = y_dec ? y_reg - ye_reg : ye_reg - y_reg;
        x_major    = adx >= ady;
        major_len  = x_major ? adx : ady;
        minor_len  = x_major ? ady : adx;
        inc_a_next = signed'({2'b00, minor_len, 1'b0});
        inc_b_next = signed'({2'b00, minor_len, 1'b0}) - signed'({2'b00, major_len, 1'b0});
    end

    // load start point, latch setup terms, step: major axis always, minor axis when decision term is not negative
    always_comb begin
        x_next       = x_reg;
        y_next       = y_reg;
        rem_next     = rem_reg;
        di_next      = di_reg;
        x_dec_next   = x_dec_reg;
        y_dec_next   = y_dec_reg;
        x_major_next = x_major_reg;
        step_x       = 1'b0;
        step_y       = 1'b0;
        if (cmd.load) begin
            x_next = x_start;
            y_next = y_start;
        end else if (cmd.setup) begin
            x_dec_next   = x_dec;
            y_dec_next   = y_dec;
            x_major_next = x_major;
            rem_next     = major_len;
            di_next      = inc_a_next - signed'({3'b000, major_len});
        end else if (cmd.step) begin
            rem_next = rem_reg - 1'b1;
            if (di_reg[DW-1]) begin
                di_next = di_reg + inc_a_reg;
            end else begin
                di_next = di_reg + inc_b_reg;
            end
            step_x = x_major_reg || !di_reg[DW-1];
            step_y = !x_major_reg || !di_reg[DW-1];
            if (step_x) begin
                x_next = x_dec_reg ? x_reg - 1'b1 : x_reg + 1'b1;
            end
            if (step_y) begin
                y_next = y_dec_reg ? y_reg - 1'b1 : y_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        rem_reg     <= rem_next;
        di_reg      <= di_next;
        x_dec_reg   <= x_dec_next;
        y_dec_reg   <= y_dec_next;
        x_major_reg <= x_major_next;
        if (cmd.load) begin
            xe_reg    <= x_end;
            ye_reg    <= y_end;
            color_reg <= color;
        end
        if (cmd.setup) begin
            inc_a_reg <= inc_a_next;
            inc_b_reg <= inc_b_next;
        end
    end

    assign sts.last    = rem_reg == '0;
    assign pixel_x     = x_reg;
    assign pixel_y     = y_reg;
    assign pixel_color = color_reg;
    assign last_pixel  = sts.last;

endmodule

`default_nettype wire

### rtl/line_rasterizer_unit.sv
// line_rasterizer_unit: Bresenham line generator.
// Input channel (s_*): one word per line command, start point, end point
// and color. s_ready is high only while no line is being drawn.
// Output channel (m_*): one word per pixel, from start to end point,
// both included; m_last_pixel marks the end point.
// After the command is taken, a setup state computes the step terms, then the
// first pixel is shown. Pixels then follow at one per cycle while m_ready is high.
// A command drawing N pixels (N = larger axis distance + 1, at most
// 2^COORD_BITS) is stepped by the single step unit, which advances the
// decision term once per pixel.
// Stall: when m_ready is low the current pixel is held unchanged and the
// stepping stops until it is taken.
// Reset (aresetn low, synchronous): the controller returns to idle, any line
// in progress is dropped and s_ready rises again.
`default_nettype none

module line_rasterizer_unit #(
    parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF,
    parameter int COLOR_BITS = lrast_pkg::COLOR_BITS_DEF
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire [COORD_BITS-1:0]  s_x_start,
    input  wire [COORD_BITS-1:0]  s_y_start,
    input  wire [COORD_BITS-1:0]  s_x_end,
    input  wire [COORD_BITS-1:0]  s_y_end,
    input  wire [COLOR_BITS-1:0]  s_color,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic [COLOR_BITS-1:0] m_pixel_color,
    output logic                  m_last_pixel
);
    import lrast_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lrast_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lrast_dp #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_dp (
        .aclk        (aclk),
        .cmd         (cmd),
        .sts         (sts),
        .x_start     (s_x_start),
        .y_start     (s_y_start),
        .x_end       (s_x_end),
        .y_end       (s_y_end),
        .color       (s_color),
        .pixel_x     (m_pixel_x),
        .pixel_y     (m_pixel_y),
        .pixel_color (m_pixel_color),
        .last_pixel  (m_last_pixel)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("command taken while pixels pending");

    a_setup_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!m_valid && !s_ready))
        else $error("no setup cycle after command");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_pixel) |=> s_ready)
        else $error("not idle after last pixel");

    a_step_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_pixel) |=> m_valid)
        else $error("line ended before last pixel");

endmodule

`default_nettype wire
